// ----- src/hse_pkg.sv -----
// Shared constants and types of the histogram equalizer.
package hse_pkg;

   // Largest count a bin or the frame total may reach.
   localparam int unsigned MAX_FRAME_PIXELS = 4194304;

   // Width that holds every count from zero up to the frame maximum.
   localparam int unsigned CNT_W = $clog2(MAX_FRAME_PIXELS + 1);

   localparam int unsigned PIX_W    = 8;
   localparam int unsigned NUM_BINS = 1 << PIX_W;
   localparam int unsigned BIN_AW   = PIX_W;

   // Scaled cumulative count: (2^PIX_W - 1) * cum, with cum never above the total.
   localparam int unsigned NUM_W  = CNT_W + PIX_W;
   localparam int unsigned STEP_W = $clog2(PIX_W);

   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [PIX_W-1:0]  pixel_type;
   typedef logic [BIN_AW-1:0] bin_addr_type;

   // Handshake between the sequencer and the divider.
   typedef struct packed {
      logic      start;
      count_type cum;
      count_type total;
   } div_req_type;

   typedef struct packed {
      logic      done;
      pixel_type quot;
   } div_rsp_type;

endpackage

// ----- src/hse_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hse_ram #(
   parameter int unsigned DATA_W = 8,
   parameter int unsigned DEPTH  = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/hse_div.sv -----
// Restoring divider: one quotient bit per cycle of floor(255 * cum / total).
module hse_div (
   input  logic                clock,
   input  logic                reset,
   input  hse_pkg::div_req_type req,
   output hse_pkg::div_rsp_type rsp
);

   logic                       busy_ff, busy_in;
   logic [hse_pkg::STEP_W-1:0] step_ff, step_in;
   logic [hse_pkg::NUM_W-1:0]  rem_ff, rem_in;
   logic [hse_pkg::NUM_W-1:0]  den_ff, den_in;
   hse_pkg::pixel_type         quot_ff, quot_in;

   logic [hse_pkg::NUM_W:0]    trial;
   logic                       fits;
   logic [hse_pkg::NUM_W-1:0]  cum_wide;

   assign cum_wide = hse_pkg::NUM_W'(req.cum);
   assign trial    = {1'b0, rem_ff} - {1'b0, den_ff};
   assign fits     = !trial[hse_pkg::NUM_W];

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (req.start) begin
         busy_in = 1'b1;
         step_in = hse_pkg::STEP_W'(hse_pkg::PIX_W - 1);
         // times (2^PIX_W - 1) as shift and subtract
         rem_in  = (cum_wide << hse_pkg::PIX_W) - cum_wide;
         den_in  = hse_pkg::NUM_W'(req.total) << (hse_pkg::PIX_W - 1);
         quot_in = '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = trial[hse_pkg::NUM_W-1:0];
         end
         quot_in = {quot_ff[hse_pkg::PIX_W-2:0], fits};
         den_in  = den_ff >> 1;
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign rsp.done = busy_ff && (step_ff == '0);
   assign rsp.quot = quot_in;

endmodule

// ----- src/histogram_equalizer.sv -----
// Top level of the two-pass 8-bit grayscale histogram equalizer.
//
// Usage:
//  - req channel (req_valid/req_stall) carries one pixel item: req_action picks
//    the pass (0 count, 1 map), req_pixel the gray level, req_last the frame end.
//  - rsp channel (rsp_valid/rsp_stall) returns one item per map item:
//    rsp_pixel_out = table entry of the pixel, rsp_last_out = its last flag.
//  - Count items give no result. A count item passes bin read and bin write
//    back, then returns to idle.
//  - The count item marked last then walks all 256 bins, each in the steps
//    read, accumulate, 8 divider steps and table write; the walk's pace is
//    set by the one-bit-per-cycle divider. With an empty frame the walk only
//    clears bins.
//  - A map item passes table read and output load, then returns to idle;
//    its result is registered once the table is read and the output is free.
//  - Reset runs a clearing pass over all 256 entries of both RAMs; req_stall
//    stays high meanwhile.
//  - The output register holds a result while rsp_stall is high; the next item
//    is still accepted, and a map item waits to load until the register frees.
module histogram_equalizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_action,
   input  logic [7:0] req_pixel,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_pixel_out,
   output logic       rsp_last_out
);

   typedef enum logic [9:0] {
      ST_CLEAR    = 10'b0000000001,
      ST_IDLE     = 10'b0000000010,
      ST_CNT_RD   = 10'b0000000100,
      ST_CNT_WR   = 10'b0000001000,
      ST_WALK_RD  = 10'b0000010000,
      ST_WALK_ACC = 10'b0000100000,
      ST_WALK_DIV = 10'b0001000000,
      ST_WALK_WR  = 10'b0010000000,
      ST_MAP_RD   = 10'b0100000000,
      ST_MAP_OUT  = 10'b1000000000
   } state_type;

   localparam hse_pkg::bin_addr_type LAST_BIN = hse_pkg::BIN_AW'(hse_pkg::NUM_BINS - 1);
   localparam hse_pkg::count_type    MAX_CNT  = hse_pkg::CNT_W'(hse_pkg::MAX_FRAME_PIXELS);

   state_type             state_ff, state_in;
   hse_pkg::bin_addr_type idx_ff, idx_in;
   hse_pkg::count_type    total_ff, total_in;
   hse_pkg::count_type    cum_ff, cum_in;
   hse_pkg::pixel_type    pixel_ff, pixel_in;
   logic                  last_ff, last_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   hse_pkg::pixel_type    rsp_pixel_ff, rsp_pixel_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Bin RAM ports
   logic                  bin_wr_en;
   hse_pkg::bin_addr_type bin_wr_addr;
   hse_pkg::count_type    bin_wr_data;
   hse_pkg::bin_addr_type bin_rd_addr;
   hse_pkg::count_type    bin_rd_data;

   // Table RAM ports
   logic                  map_wr_en;
   hse_pkg::pixel_type    map_wr_data;
   hse_pkg::pixel_type    map_rd_data;

   hse_pkg::div_req_type  div_req;
   hse_pkg::div_rsp_type  div_rsp;

   logic                  req_accept;
   logic                  out_free;
   logic [hse_pkg::CNT_W:0] cum_sum;
   hse_pkg::count_type    cum_clip;

   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Clip the running sum at the total: from there on every entry is full scale.
   assign cum_sum  = {1'b0, cum_ff} + {1'b0, bin_rd_data};
   assign cum_clip = (cum_sum >= {1'b0, total_ff}) ? total_ff
                                                  : cum_sum[hse_pkg::CNT_W-1:0];

   assign div_req.start = (state_ff == ST_WALK_ACC) && (total_ff != '0);
   assign div_req.cum   = cum_clip;
   assign div_req.total = total_ff;

   hse_ram #(
      .DATA_W (hse_pkg::CNT_W),
      .DEPTH  (hse_pkg::NUM_BINS)
   ) u_bin_ram (
      .clock   (clock),
      .wr_en   (bin_wr_en),
      .wr_addr (bin_wr_addr),
      .wr_data (bin_wr_data),
      .rd_addr (bin_rd_addr),
      .rd_data (bin_rd_data)
   );

   hse_ram #(
      .DATA_W (hse_pkg::PIX_W),
      .DEPTH  (hse_pkg::NUM_BINS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (idx_ff),
      .wr_data (map_wr_data),
      .rd_addr (pixel_ff),
      .rd_data (map_rd_data)
   );

   hse_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      total_in     = total_ff;
      cum_in       = cum_ff;
      pixel_in     = pixel_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_last_in  = rsp_last_ff;

      bin_wr_en    = 1'b0;
      bin_wr_addr  = idx_ff;
      bin_wr_data  = '0;
      bin_rd_addr  = idx_ff;
      map_wr_en    = 1'b0;
      map_wr_data  = '0;

      // Drop a result once the receiver takes it.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            bin_wr_en = 1'b1;
            map_wr_en = 1'b1;
            idx_in    = idx_ff + 1'b1;
            if (idx_ff == LAST_BIN) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               pixel_in  = req_pixel;
               last_in   = req_last;
               state_in  = req_action ? ST_MAP_RD : ST_CNT_RD;
            end
         end
         ST_CNT_RD: begin
            bin_rd_addr = pixel_ff;
            state_in    = ST_CNT_WR;
         end
         ST_CNT_WR: begin
            bin_wr_en   = 1'b1;
            bin_wr_addr = pixel_ff;
            bin_wr_data = (bin_rd_data < MAX_CNT) ? bin_rd_data + 1'b1 : bin_rd_data;
            if (total_ff < MAX_CNT) begin
               total_in = total_ff + 1'b1;
            end
            if (last_ff) begin
               cum_in   = '0;
               state_in = ST_WALK_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_WALK_RD: begin
            state_in = ST_WALK_ACC;
         end
         ST_WALK_ACC: begin
            // Clear the bin as it is consumed.
            bin_wr_en = 1'b1;
            cum_in    = cum_clip;
            if (total_ff != '0) begin
               state_in = ST_WALK_DIV;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = (idx_ff == LAST_BIN) ? ST_IDLE : ST_WALK_RD;
            end
         end
         ST_WALK_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_WALK_WR;
            end
         end
         ST_WALK_WR: begin
            map_wr_en   = 1'b1;
            map_wr_data = div_rsp.quot;
            idx_in      = idx_ff + 1'b1;
            if (idx_ff == LAST_BIN) begin
               total_in = '0;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_WALK_RD;
            end
         end
         ST_MAP_RD: begin
            state_in = ST_MAP_OUT;
         end
         ST_MAP_OUT: begin
            // Hold until the output register is free.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pixel_in = map_rd_data;
               rsp_last_in  = last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cum_ff       <= cum_in;
      pixel_ff     <= pixel_in;
      last_ff      <= last_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_last_out  = rsp_last_ff;

   // A new result is loaded only out of a map item.
   a_rsp_from_map: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !(rsp_valid_ff && rsp_stall) && (state_ff != ST_MAP_OUT))
         |-> !rsp_valid_ff || !rsp_stall ? 1'b0 : 1'b1)
      else $error("result loaded outside a map item");

   // The divider finishes only while the walk waits on it.
   a_div_done_in_walk: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_WALK_DIV))
      else $error("divider done outside the walk");

   // A finished table build leaves the total cleared.
   a_total_cleared: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_WALK_WR) && (idx_ff == LAST_BIN)) |=> (total_ff == '0))
      else $error("total not cleared after table build");

   // The total never passes the frame maximum.
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      (total_ff <= MAX_CNT))
      else $error("pixel total above frame maximum");

   // A map item that was accepted reaches the output stage after the table read state.
   a_map_latency: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_action) |=> ##1 (state_ff == ST_MAP_OUT))
      else $error("map item lost in sequencer");

endmodule
